// File: src/wtdf_pkg.sv
// shared constants for the wheel trial-division factorizer
// no dependencies; imported by the top level and the divider

package wtdf_pkg;

  // default operand width
  localparam int unsigned VALUE_BITS_DEF = 31;

  // result field widths and limits
  localparam int unsigned EXP_BITS    = 5;
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_BITS    = $clog2(MAX_RESULTS + 1);

  // mod-30 wheel over 2, 3, 5
  localparam int unsigned WHEEL_START = 7;
  localparam int unsigned WHEEL_SIZE  = 8;
  localparam int unsigned WPOS_BITS   = $clog2(WHEEL_SIZE);
  localparam int unsigned INC_BITS    = 3;

  localparam logic [INC_BITS-1:0] WHEEL_INC [WHEEL_SIZE] = '{
    3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd6, 3'd2, 3'd6
  };

endpackage

// File: src/wtdf_divider.sv
// restoring radix-2 divider, one quotient bit per cycle
// uses wtdf_pkg; shared by every trial division of the factorizer

module wtdf_divider #(
  parameter int unsigned VALUE_BITS = wtdf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [VALUE_BITS-1:0] remainder_o
);
  import wtdf_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] dvs_q;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[VALUE_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
    quo_d = {quo_q[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(VALUE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: src/wheel_trial_division_factorizer_top.sv
// wheel trial-division factorizer: one value in, a run of (prime, exponent) beats out
// each trial division runs on the shared bit-serial divider; roughly 12400 trials
// for a large prime at 31 bits
// throughput: one value at a time; in_stall_o is high from accept until the last beat is queued
// reset: rst_ni asynchronous active low, clears the sequencer, holding slot and output beat
// uses wtdf_pkg and wtdf_divider

module wheel_trial_division_factorizer_top #(
  parameter int unsigned VALUE_BITS = wtdf_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [VALUE_BITS-1:0]          value_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [VALUE_BITS-1:0]          prime_o,
  output logic [wtdf_pkg::EXP_BITS-1:0]  exponent_o,
  output logic                           empty_res_o,
  output logic                           last_o
);
  import wtdf_pkg::*;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a value
    S_START,  // kick the divider with remainder / divisor
    S_WAIT,   // wait for quotient and remainder
    S_EMIT,   // queue (divisor, exponent) if the divisor divided
    S_ADV,    // step to the next trial divisor
    S_FINAL,  // queue a leftover cofactor above one
    S_FLUSH   // send the held beat with last set
  } state_e;

  state_e                 state_q;

  // working values
  logic [VALUE_BITS-1:0]  rem_q;     // cofactor not yet divided out
  logic [VALUE_BITS-1:0]  div_q;     // current trial divisor
  logic [WPOS_BITS-1:0]   wpos_q;    // wheel position
  logic                   wheel_q;   // past 2, 3 and 5
  logic [EXP_BITS-1:0]    exp_q;     // multiplicity of current divisor
  logic [CNT_BITS-1:0]    cnt_q;     // beats produced for this value

  // holding slot: a beat waits here until we know whether it is the last one
  logic                   pend_valid_q;
  logic [VALUE_BITS-1:0]  pend_prime_q;
  logic [EXP_BITS-1:0]    pend_exp_q;
  logic                   pend_empty_q;

  // output beat register
  logic                   out_valid_q;
  logic [VALUE_BITS-1:0]  out_prime_q;
  logic [EXP_BITS-1:0]    out_exp_q;
  logic                   out_empty_q;
  logic                   out_last_q;

  // divider hookup
  logic                   dv_start;
  logic                   dv_done;
  logic [VALUE_BITS-1:0]  dv_quo;
  logic [VALUE_BITS-1:0]  dv_rem;

  logic                   in_fire;
  logic                   out_free;
  logic                   room;
  logic                   out_load;
  logic [EXP_BITS-1:0]    exp_inc;

  assign dv_start = (state_q == S_START);
  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  // output register can take a beat this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // holding slot can take a new beat (pushing the old one out if needed)
  assign room     = !pend_valid_q || out_free;
  // exponent saturates at all ones
  assign exp_inc  = (exp_q == '1) ? exp_q : exp_q + EXP_BITS'(1);

  // output register gets a new beat this cycle
  always_comb begin
    out_load = 1'b0;
    case (state_q)
      S_EMIT:  out_load = (cnt_q != CNT_BITS'(MAX_RESULTS)) && room && pend_valid_q;
      S_FINAL: out_load = (rem_q > VALUE_BITS'(1)) && (cnt_q != CNT_BITS'(MAX_RESULTS)) &&
                          room && pend_valid_q;
      S_FLUSH: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  wtdf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .dividend_i  (rem_q),
    .divisor_i   (div_q),
    .done_o      (dv_done),
    .quotient_o  (dv_quo),
    .remainder_o (dv_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rem_q        <= '0;
      div_q        <= '0;
      wpos_q       <= '0;
      wheel_q      <= 1'b0;
      exp_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_prime_q <= '0;
      pend_exp_q   <= '0;
      pend_empty_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_prime_q  <= '0;
      out_exp_q    <= '0;
      out_empty_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      // beat taken downstream and nothing new loaded behind it
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            rem_q   <= value_i;
            wpos_q  <= '0;
            wheel_q <= 1'b0;
            exp_q   <= '0;
            cnt_q   <= '0;
            if (value_i < VALUE_BITS'(2)) begin
              // zero or one: a single empty marker
              div_q        <= '0;
              pend_valid_q <= 1'b1;
              pend_prime_q <= '0;
              pend_exp_q   <= '0;
              pend_empty_q <= 1'b1;
              state_q      <= S_FLUSH;
            end else begin
              div_q   <= VALUE_BITS'(2);
              state_q <= S_START;
            end
          end
        end

        S_START: begin
          state_q <= S_WAIT;
        end

        S_WAIT: begin
          if (dv_done) begin
            if (wheel_q && (exp_q == '0) && (div_q > dv_quo)) begin
              // divisor squared exceeds the cofactor
              state_q <= S_FINAL;
            end else if (dv_rem == '0) begin
              rem_q   <= dv_quo;
              exp_q   <= exp_inc;
              state_q <= S_START;
            end else if (exp_q != '0) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_ADV;
            end
          end
        end

        S_EMIT: begin
          if (cnt_q == CNT_BITS'(MAX_RESULTS)) begin
            // result limit reached, factor dropped
            state_q <= S_ADV;
          end else if (room) begin
            if (pend_valid_q) begin
              out_valid_q <= 1'b1;
              out_prime_q <= pend_prime_q;
              out_exp_q   <= pend_exp_q;
              out_empty_q <= pend_empty_q;
              out_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_prime_q <= div_q;
            pend_exp_q   <= exp_q;
            pend_empty_q <= 1'b0;
            cnt_q        <= cnt_q + CNT_BITS'(1);
            state_q      <= S_ADV;
          end
        end

        S_ADV: begin
          exp_q   <= '0;
          state_q <= S_START;
          if (wheel_q) begin
            div_q  <= div_q + VALUE_BITS'(WHEEL_INC[wpos_q]);
            wpos_q <= wpos_q + WPOS_BITS'(1);
          end else if (div_q == VALUE_BITS'(5)) begin
            // 2, 3, 5 done; enter the wheel
            div_q   <= VALUE_BITS'(WHEEL_START);
            wpos_q  <= '0;
            wheel_q <= 1'b1;
          end else if (div_q == VALUE_BITS'(2)) begin
            div_q <= VALUE_BITS'(3);
          end else begin
            div_q <= VALUE_BITS'(5);
          end
        end

        S_FINAL: begin
          if ((rem_q <= VALUE_BITS'(1)) || (cnt_q == CNT_BITS'(MAX_RESULTS))) begin
            state_q <= S_FLUSH;
          end else if (room) begin
            // leftover cofactor is prime
            if (pend_valid_q) begin
              out_valid_q <= 1'b1;
              out_prime_q <= pend_prime_q;
              out_exp_q   <= pend_exp_q;
              out_empty_q <= pend_empty_q;
              out_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_prime_q <= rem_q;
            pend_exp_q   <= EXP_BITS'(1);
            pend_empty_q <= 1'b0;
            exp_q        <= EXP_BITS'(1);
            cnt_q        <= cnt_q + CNT_BITS'(1);
            state_q      <= S_FLUSH;
          end
        end

        S_FLUSH: begin
          // every run holds at least one beat here
          if (out_free) begin
            out_valid_q  <= pend_valid_q;
            out_prime_q  <= pend_prime_q;
            out_exp_q    <= pend_exp_q;
            out_empty_q  <= pend_empty_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign prime_o     = out_prime_q;
  assign exponent_o  = out_exp_q;
  assign empty_res_o = out_empty_q;
  assign last_o      = out_last_q;

endmodule

// File: dv/wheel_trial_division_factorizer_top_test.sv
// self-checking testbench for wheel_trial_division_factorizer_top
// depends on wtdf_pkg and the factorizer rtl; predicts every factor beat internally
`timescale 1ns / 1ps

module wheel_trial_division_factorizer_top_test;

  import wtdf_pkg::*;

  localparam int unsigned VB = VALUE_BITS_DEF;
  // the largest prime keeps the block busy through its whole trial run with no beat moving,
  // so the idle limit sits several times above the length of that run
  localparam int unsigned IDLE_LIMIT = 2000000;
  localparam int unsigned TAIL_CYCLES = 4 * (VB + 3);
  localparam int unsigned EXP_SAT = 31;

  // one expected result beat, same fields as the result channel
  typedef struct packed {
    logic [VB-1:0]       prime;
    logic [EXP_BITS-1:0] exponent;
    logic                empty_res;
    logic                last;
  } factor_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [VB-1:0]       value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VB-1:0]       prime_o;
  logic [EXP_BITS-1:0] exponent_o;
  logic                empty_res_o;
  logic                last_o;

  wheel_trial_division_factorizer_top #(
    .VALUE_BITS(VB)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_o     (prime_o),
    .exponent_o  (exponent_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

  // expected beats, oldest first
  factor_beat_t expected_factors[$];

  // predictor state, mirrors what the block leaves behind after each value
  longint unsigned cofactor;
  longint unsigned divisor;
  int unsigned     wheel_idx;
  int unsigned     mult_count;
  int unsigned     beats_in_run;
  factor_beat_t    held_beat;
  bit              have_held;

  int unsigned error_count;
  int unsigned values_sent;
  int unsigned beats_checked;
  int unsigned idle_cycles;
  // when set, neither side inserts idle cycles
  bit          quiet_mode;

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // the newest beat is held back so the final one of a run can get its last flag
  function automatic void record_factor(longint unsigned p, int unsigned e, bit empty);
    factor_beat_t b;
    if (beats_in_run >= MAX_RESULTS) return;
    b.prime     = p[VB-1:0];
    b.exponent  = (e > EXP_SAT) ? EXP_SAT[EXP_BITS-1:0] : e[EXP_BITS-1:0];
    b.empty_res = empty;
    b.last      = 1'b0;
    if (have_held) expected_factors.push_back(held_beat);
    held_beat    = b;
    have_held    = 1'b1;
    beats_in_run = beats_in_run + 1;
  endfunction

  // divide out p completely, one beat if it divides at all
  function automatic void divide_out(longint unsigned p);
    mult_count = 0;
    while (cofactor % p == 0) begin
      cofactor = cofactor / p;
      if (mult_count < EXP_SAT) mult_count = mult_count + 1;
    end
    if (mult_count != 0) record_factor(p, mult_count, 1'b0);
  endfunction

  function automatic void predict_factors(logic [VB-1:0] v);
    longint unsigned n;
    n            = v;
    beats_in_run = 0;
    have_held    = 1'b0;
    if (n < 2) begin
      // zero and one: a single empty marker
      cofactor   = n;
      divisor    = 0;
      wheel_idx  = 0;
      mult_count = 0;
      record_factor(0, 0, 1'b1);
    end else begin
      cofactor = n;
      divide_out(2);
      divide_out(3);
      divide_out(5);
      divisor   = WHEEL_START;
      wheel_idx = 0;
      // stop once divisor squared passes the cofactor
      while (divisor <= cofactor / divisor) begin
        divide_out(divisor);
        divisor   = divisor + WHEEL_INC[wheel_idx];
        wheel_idx = (wheel_idx + 1) % WHEEL_SIZE;
      end
      // whatever is left above one is prime
      if (cofactor > 1) begin
        mult_count = 1;
        record_factor(cofactor, 1, 1'b0);
      end
    end
    held_beat.last = 1'b1;
    expected_factors.push_back(held_beat);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall driver and checker
  // ---------------------------------------------------------------------------

  // before every beat the sink holds stall high for a randomly drawn wait, except in quiet mode
  initial begin : sink_stall
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = quiet_mode ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  // compare each accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    factor_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected beat: prime %0d exponent %0d empty_res %0b last %0b",
               prime_o, exponent_o, empty_res_o, last_o);
        error_count = error_count + 1;
      end else begin
        want = expected_factors.pop_front();
        beats_checked = beats_checked + 1;
        if (prime_o !== want.prime) begin
          $error("prime mismatch: expected %0d, actual %0d", want.prime, prime_o);
          error_count = error_count + 1;
        end
        if (exponent_o !== want.exponent) begin
          $error("exponent mismatch: expected %0d, actual %0d", want.exponent, exponent_o);
          error_count = error_count + 1;
        end
        if (empty_res_o !== want.empty_res) begin
          $error("empty_res mismatch: expected %0b, actual %0b", want.empty_res, empty_res_o);
          error_count = error_count + 1;
        end
        if (last_o !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, last_o);
          error_count = error_count + 1;
        end
      end
    end
  end

  // watchdog: too long without any beat moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d beats still expected",
               idle_cycles, expected_factors.size());
      $display("wheel_trial_division_factorizer_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after the beat is taken;
  // valid stays high across back-to-back values
  task automatic send_value(logic [VB-1:0] v);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_factors(v);
    values_sent = values_sent + 1;
    @(negedge clk_i);
  endtask

  // hold the input off until every expected beat has come back
  task automatic wait_for_all_factors();
    in_valid_i <= 1'b0;
    while (expected_factors.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero and one give the empty marker
  task automatic test_empty_inputs();
    send_value('0);
    send_value(31'd1);
  endtask

  // the wheel primes, first wheel divisors, and a divisor squared equal to the cofactor
  task automatic test_small_values();
    send_value(31'd2);
    send_value(31'd3);
    send_value(31'd4);
    send_value(31'd5);
    send_value(31'd7);
    send_value(31'd25);
    send_value(31'd30);
    send_value(31'd49);
    send_value(31'd121);
    send_value(31'd169);
  endtask

  // high exponents: 2^30, 3^19, 5^13, 7^11
  task automatic test_high_exponents();
    send_value(31'd1073741824);
    send_value(31'd1162261467);
    send_value(31'd1220703125);
    send_value(31'd1977326743);
  endtask

  // nine distinct primes is the most that fits, plus a few mixed cases
  task automatic test_many_factors();
    send_value(31'd223092870);
    send_value(31'd2147483646);
    send_value(31'd999983);
  endtask

  // all ones is prime: the longest trial division run, then drain
  task automatic test_largest_prime();
    send_value('1);
    wait_for_all_factors();
  endtask

  // products of small random factors, clipped to the field width
  task automatic test_random_products(int unsigned count);
    longint unsigned product;
    int unsigned     factor;
    int unsigned     top;
    int unsigned     k;
    repeat (count) begin
      product = 1;
      k       = $urandom_range(1, 8);
      top     = ($urandom_range(0, 3) == 0) ? 5000 : 200;
      repeat (k) begin
        factor = $urandom_range(2, top);
        if (product * factor < (64'd1 << VB)) product = product * factor;
      end
      send_value(product[VB-1:0]);
    end
  endtask

  // narrow random values, sometimes shifted up so the top bits move too
  task automatic test_random_narrow(int unsigned count);
    logic [VB-1:0] v;
    int unsigned   width;
    int unsigned   shift;
    repeat (count) begin
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      v     = VB'($urandom & ((32'd1 << width) - 1));
      if ($urandom_range(0, 4) == 0) begin
        shift = $urandom_range(0, VB - width);
        v     = v << shift;
      end
      send_value(v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    error_count   = 0;
    values_sent   = 0;
    beats_checked = 0;
    idle_cycles   = 0;
    quiet_mode    = 1'b0;
    have_held     = 1'b0;
    beats_in_run  = 0;
    cofactor      = 0;
    divisor       = 0;
    wheel_idx     = 0;
    mult_count    = 0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_inputs();
    test_small_values();
    test_high_exponents();
    test_many_factors();
    test_largest_prime();

    test_random_products(30);
    // a stretch with no idling on either side
    quiet_mode = 1'b1;
    test_random_products(20);
    test_random_narrow(15);
    quiet_mode = 1'b0;
    wait_for_all_factors();
    test_random_narrow(15);

    wait_for_all_factors();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_factors.size() != 0) begin
      $error("%0d expected beats never arrived", expected_factors.size());
      error_count = error_count + 1;
    end

    $display("factorized %0d values (trivial, wheel edges, high exponents, nine primes,",
             values_sent);
    $display("largest prime, random products and narrow values), %0d beats checked",
             beats_checked);
    if (error_count == 0) begin
      $display("wheel_trial_division_factorizer_top test passed");
    end else begin
      $display("wheel_trial_division_factorizer_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/wtdf_pkg.sv
src/wtdf_divider.sv
src/wheel_trial_division_factorizer_top.sv
dv/wheel_trial_division_factorizer_top_test.sv
